FILE: hdl/gne_pkg.sv
// shared types, codes and widths of the grid neighbor enumerator
package gne_pkg;

    localparam int ID_W      = 24;
    localparam int ST_W      = 2;
    localparam int CFG_SW    = 9;
    localparam int PADDR_W   = 4;
    localparam int DIV_STEPS = ID_W / 2;
    localparam int PC_W      = 6;
    localparam int KIND_W    = 3;
    localparam int OFF_W     = 2;
    localparam int COND_W    = 2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_NONE  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic [1:0] REG_SLICES_X = 2'd0;
    localparam logic [1:0] REG_SLICES_Y = 2'd1;
    localparam logic [1:0] REG_SLICES_Z = 2'd2;
    localparam logic [1:0] REG_DIAGONAL = 2'd3;

    localparam logic [KIND_W-1:0] K_WAIT  = 3'd0;
    localparam logic [KIND_W-1:0] K_LOAD  = 3'd1;
    localparam logic [KIND_W-1:0] K_DIV_X = 3'd2;
    localparam logic [KIND_W-1:0] K_MID   = 3'd3;
    localparam logic [KIND_W-1:0] K_DIV_Y = 3'd4;
    localparam logic [KIND_W-1:0] K_FLAGS = 3'd5;
    localparam logic [KIND_W-1:0] K_EMIT  = 3'd6;
    localparam logic [KIND_W-1:0] K_END   = 3'd7;

    localparam logic [OFF_W-1:0] OFF_Z = 2'd0;
    localparam logic [OFF_W-1:0] OFF_P = 2'd1;
    localparam logic [OFF_W-1:0] OFF_M = 2'd2;

    localparam logic [COND_W-1:0] JC_SEQ   = 2'd0;
    localparam logic [COND_W-1:0] JC_GO    = 2'd1;
    localparam logic [COND_W-1:0] JC_RANGE = 2'd2;
    localparam logic [COND_W-1:0] JC_DIAG  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OFF_W-1:0]  off_x;
        logic [OFF_W-1:0]  off_y;
        logic [OFF_W-1:0]  off_z;
        logic              err;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
    } ctrl_t;

endpackage

FILE: hdl/grid_neighbor_enumerator.sv
// grid neighbor enumerator top level: microcoded sequencer and datapath
//
// Queries enter on the s_ channel (s_region_id, s_mode) with valid/ready and
// neighbor ids leave on the m_ channel, one transfer per neighbor, with
// m_last on the final transfer of a query. A region id beyond the grid gives
// one transfer with status 2; a cell with no neighbors gives one with status 1.
// Slice counts and the diagonal flag sit behind an APB port (regs at 0x0,
// 0x4, 0x8, 0xc) and are to be written only between queries; the block
// does not enforce this. One query is worked at a time. After acceptance
// the id is decoded by a shared divider, two quotient bits per cycle, once
// by slices_x and once by slices_y. The program then walks 6 axis or 26
// diagonal candidate steps, one per cycle while the output register is
// free, and one closing step. One result is held back until the next is
// known so that m_last can be set; a full output register holds the
// sequencer. Reset sets the slice counts to 1, clears the diagonal flag
// and the valid flags of the output register and the held-back result,
// and puts the program counter at its wait step.
module grid_neighbor_enumerator #(
    parameter int MAX_DIMS   = 3,
    parameter int MAX_SLICES = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gne_pkg::ID_W-1:0]      s_region_id,
    input  logic                          s_mode,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [gne_pkg::ID_W-1:0]      m_neighbor_region,
    output logic [gne_pkg::ST_W-1:0]      m_status,
    output logic                          m_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gne_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import gne_pkg::*;

    localparam int SW    = $clog2(MAX_SLICES + 1);
    localparam int NXY_W = 2 * SW;
    localparam int TOT_W = 3 * SW;
    localparam int CMP_W = (TOT_W > ID_W) ? TOT_W : ID_W + 1;
    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [PC_W-1:0] PC_WAIT  = 6'd0;
    localparam logic [PC_W-1:0] PC_DIAG  = 6'd12;
    localparam logic [PC_W-1:0] PC_FLUSH = 6'd38;
    localparam logic [PC_W-1:0] PC_ERR   = 6'd39;

    function automatic ctrl_t cw_make(input logic [KIND_W-1:0] k,
                                      input logic [OFF_W-1:0] ox,
                                      input logic [OFF_W-1:0] oy,
                                      input logic [OFF_W-1:0] oz,
                                      input logic e,
                                      input logic [COND_W-1:0] c,
                                      input logic [PC_W-1:0] t);
        ctrl_t w;
        w.kind   = k;
        w.off_x  = ox;
        w.off_y  = oy;
        w.off_z  = oz;
        w.err    = e;
        w.cond   = c;
        w.target = t;
        return w;
    endfunction

    function automatic ctrl_t emit(input logic [OFF_W-1:0] ox,
                                   input logic [OFF_W-1:0] oy,
                                   input logic [OFF_W-1:0] oz);
        return cw_make(K_EMIT, ox, oy, oz, 1'b0, JC_SEQ, PC_WAIT);
    endfunction

    function automatic ctrl_t rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        case (pc)
            6'd0:  w = cw_make(K_WAIT, OFF_Z, OFF_Z, OFF_Z, 1'b0, JC_SEQ, PC_WAIT);
            6'd1:  w = cw_make(K_LOAD, OFF_Z, OFF_Z, OFF_Z, 1'b0, JC_SEQ, PC_WAIT);
            6'd2:  w = cw_make(K_DIV_X, OFF_Z, OFF_Z, OFF_Z, 1'b0, JC_SEQ, PC_WAIT);
            6'd3:  w = cw_make(K_MID, OFF_Z, OFF_Z, OFF_Z, 1'b0, JC_RANGE, PC_ERR);
            6'd4:  w = cw_make(K_DIV_Y, OFF_Z, OFF_Z, OFF_Z, 1'b0, JC_SEQ, PC_WAIT);
            6'd5:  w = cw_make(K_FLAGS, OFF_Z, OFF_Z, OFF_Z, 1'b0, JC_DIAG, PC_DIAG);
            // axis neighborhood
            6'd6:  w = emit(OFF_M, OFF_Z, OFF_Z);
            6'd7:  w = emit(OFF_P, OFF_Z, OFF_Z);
            6'd8:  w = emit(OFF_Z, OFF_M, OFF_Z);
            6'd9:  w = emit(OFF_Z, OFF_P, OFF_Z);
            6'd10: w = emit(OFF_Z, OFF_Z, OFF_M);
            6'd11: w = cw_make(K_EMIT, OFF_Z, OFF_Z, OFF_P, 1'b0, JC_GO, PC_FLUSH);
            // diagonal neighborhood, x outermost
            6'd12: w = emit(OFF_P, OFF_P, OFF_P);
            6'd13: w = emit(OFF_P, OFF_P, OFF_Z);
            6'd14: w = emit(OFF_P, OFF_P, OFF_M);
            6'd15: w = emit(OFF_P, OFF_Z, OFF_P);
            6'd16: w = emit(OFF_P, OFF_Z, OFF_Z);
            6'd17: w = emit(OFF_P, OFF_Z, OFF_M);
            6'd18: w = emit(OFF_P, OFF_M, OFF_P);
            6'd19: w = emit(OFF_P, OFF_M, OFF_Z);
            6'd20: w = emit(OFF_P, OFF_M, OFF_M);
            6'd21: w = emit(OFF_Z, OFF_P, OFF_P);
            6'd22: w = emit(OFF_Z, OFF_P, OFF_Z);
            6'd23: w = emit(OFF_Z, OFF_P, OFF_M);
            6'd24: w = emit(OFF_Z, OFF_Z, OFF_P);
            6'd25: w = emit(OFF_Z, OFF_Z, OFF_M);
            6'd26: w = emit(OFF_Z, OFF_M, OFF_P);
            6'd27: w = emit(OFF_Z, OFF_M, OFF_Z);
            6'd28: w = emit(OFF_Z, OFF_M, OFF_M);
            6'd29: w = emit(OFF_M, OFF_P, OFF_P);
            6'd30: w = emit(OFF_M, OFF_P, OFF_Z);
            6'd31: w = emit(OFF_M, OFF_P, OFF_M);
            6'd32: w = emit(OFF_M, OFF_Z, OFF_P);
            6'd33: w = emit(OFF_M, OFF_Z, OFF_Z);
            6'd34: w = emit(OFF_M, OFF_Z, OFF_M);
            6'd35: w = emit(OFF_M, OFF_M, OFF_P);
            6'd36: w = emit(OFF_M, OFF_M, OFF_Z);
            6'd37: w = emit(OFF_M, OFF_M, OFF_M);
            6'd38: w = cw_make(K_END, OFF_Z, OFF_Z, OFF_Z, 1'b0, JC_GO, PC_WAIT);
            6'd39: w = cw_make(K_END, OFF_Z, OFF_Z, OFF_Z, 1'b1, JC_GO, PC_WAIT);
            default: w = cw_make(K_WAIT, OFF_Z, OFF_Z, OFF_Z, 1'b0, JC_GO, PC_WAIT);
        endcase
        return w;
    endfunction

    function automatic logic [SW-1:0] eff_slices(input logic [CFG_SW-1:0] v, input int dim);
        logic [SW-1:0] r;
        if (dim >= MAX_DIMS) begin
            r = SW'(1);
        end else if (v == '0) begin
            r = SW'(1);
        end else if (v > CFG_SW'(MAX_SLICES)) begin
            r = SW'(MAX_SLICES);
        end else begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    // two restoring division steps
    function automatic logic [SW+ID_W-1:0] div_step(input logic [SW-1:0] rem,
                                                    input logic [ID_W-1:0] quo,
                                                    input logic [SW-1:0] dvs);
        logic [SW:0]     trial;
        logic [SW-1:0]   r;
        logic [ID_W-1:0] q;
        r = rem;
        q = quo;
        for (int i = 0; i < 2; i++) begin
            trial = {r, q[ID_W-1]};
            q = {q[ID_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs}) begin
                r = SW'(trial - {1'b0, dvs});
                q[0] = 1'b1;
            end else begin
                r = trial[SW-1:0];
            end
        end
        return {r, q};
    endfunction

    function automatic logic [ID_W-1:0] term(input logic [OFF_W-1:0] code,
                                             input logic [ID_W-1:0] val);
        logic [ID_W-1:0] r;
        case (code)
            OFF_P:   r = val;
            OFF_M:   r = '0 - val;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic dim_ok(input logic [OFF_W-1:0] code, input logic lo,
                                    input logic hi);
        logic r;
        case (code)
            OFF_P:   r = hi;
            OFF_M:   r = lo;
            default: r = 1'b1;
        endcase
        return r;
    endfunction

    logic [CFG_SW-1:0] slices_x_reg, slices_y_reg, slices_z_reg;
    logic              diag_edges_reg;
    logic [SW-1:0]     nx, ny, nz;
    logic [NXY_W-1:0]  nxy_reg;
    logic [TOT_W-1:0]  total_reg;

    logic [PC_W-1:0]   pc_reg, pc_next;
    ctrl_t             cw;
    logic              step_done, taken;
    logic [CNT_W-1:0]  cnt_reg;

    logic [ID_W-1:0]   id_reg;
    logic              diag_reg;
    logic [SW-1:0]     rem_reg;
    logic [ID_W-1:0]   quo_reg;
    logic [SW-1:0]     c0_reg;
    logic [2:0]        lo_ok_reg, hi_ok_reg;
    logic              out_of_range;
    logic [ID_W-1:0]   cand_id;
    logic              cand_ok;

    logic              pend_valid_reg;
    logic [ID_W-1:0]   pend_id_reg;
    logic              m_valid_reg, m_last_reg;
    logic [ID_W-1:0]   m_id_reg;
    logic [ST_W-1:0]   m_status_reg;
    logic              out_free, out_load, pend_load, pend_clr, out_last;
    logic [ID_W-1:0]   out_id;
    logic [ST_W-1:0]   out_st;
    logic              cfg_wr;

    // configuration port
    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slices_x_reg   <= CFG_SW'(1);
            slices_y_reg   <= CFG_SW'(1);
            slices_z_reg   <= CFG_SW'(1);
            diag_edges_reg <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[PADDR_W-1:2])
                REG_SLICES_X: slices_x_reg   <= pwdata[CFG_SW-1:0];
                REG_SLICES_Y: slices_y_reg   <= pwdata[CFG_SW-1:0];
                REG_SLICES_Z: slices_z_reg   <= pwdata[CFG_SW-1:0];
                REG_DIAGONAL: diag_edges_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[PADDR_W-1:2])
            REG_SLICES_X: prdata = 32'(slices_x_reg);
            REG_SLICES_Y: prdata = 32'(slices_y_reg);
            REG_SLICES_Z: prdata = 32'(slices_z_reg);
            REG_DIAGONAL: prdata = 32'(diag_edges_reg);
            default:      prdata = '0;
        endcase
    end

    // effective grid size
    always_comb begin
        nx = eff_slices(slices_x_reg, 0);
        ny = eff_slices(slices_y_reg, 1);
        nz = eff_slices(slices_z_reg, 2);
    end

    always_ff @(posedge aclk) begin
        nxy_reg   <= NXY_W'(nx) * NXY_W'(ny);
        total_reg <= TOT_W'(nxy_reg) * TOT_W'(nz);
    end

    // sequencer
    assign cw           = rom(pc_reg);
    assign out_free     = ~m_valid_reg | m_ready;
    assign out_of_range = CMP_W'(id_reg) >= CMP_W'(total_reg);
    assign cand_id      = id_reg + term(cw.off_x, ID_W'(1)) + term(cw.off_y, ID_W'(nx))
                          + term(cw.off_z, ID_W'(nxy_reg));
    assign cand_ok      = dim_ok(cw.off_x, lo_ok_reg[0], hi_ok_reg[0])
                          & dim_ok(cw.off_y, lo_ok_reg[1], hi_ok_reg[1])
                          & dim_ok(cw.off_z, lo_ok_reg[2], hi_ok_reg[2]);

    always_comb begin
        unique case (cw.kind) inside
            K_WAIT:           step_done = s_valid;
            K_DIV_X, K_DIV_Y: step_done = (cnt_reg == CNT_W'(DIV_STEPS - 1));
            K_EMIT:           step_done = ~cand_ok | ~pend_valid_reg | out_free;
            K_END:            step_done = out_free;
            default:          step_done = 1'b1;
        endcase
    end

    always_comb begin
        unique case (cw.cond)
            JC_GO:    taken = 1'b1;
            JC_RANGE: taken = out_of_range;
            JC_DIAG:  taken = diag_reg;
            default:  taken = 1'b0;
        endcase
        if (!step_done) begin
            pc_next = pc_reg;
        end else if (taken) begin
            pc_next = cw.target;
        end else begin
            pc_next = pc_reg + PC_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg  <= PC_WAIT;
            cnt_reg <= '0;
        end else begin
            pc_reg <= pc_next;
            if ((cw.kind == K_DIV_X || cw.kind == K_DIV_Y) && !step_done) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else begin
                cnt_reg <= '0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (cw.kind)
            K_WAIT: begin
                if (s_valid) begin
                    id_reg   <= s_region_id;
                    diag_reg <= s_mode | diag_edges_reg;
                end
            end
            K_LOAD: begin
                rem_reg <= '0;
                quo_reg <= id_reg;
            end
            K_DIV_X: {rem_reg, quo_reg} <= div_step(rem_reg, quo_reg, nx);
            K_MID: begin
                c0_reg  <= rem_reg;
                rem_reg <= '0;
            end
            K_DIV_Y: {rem_reg, quo_reg} <= div_step(rem_reg, quo_reg, ny);
            K_FLAGS: begin
                lo_ok_reg[0] <= c0_reg != '0;
                lo_ok_reg[1] <= rem_reg != '0;
                lo_ok_reg[2] <= quo_reg[SW-1:0] != '0;
                hi_ok_reg[0] <= ({1'b0, c0_reg} + (SW+1)'(1)) < {1'b0, nx};
                hi_ok_reg[1] <= ({1'b0, rem_reg} + (SW+1)'(1)) < {1'b0, ny};
                hi_ok_reg[2] <= ({1'b0, quo_reg[SW-1:0]} + (SW+1)'(1)) < {1'b0, nz};
            end
            default: ;
        endcase
    end

    // result hold-back and output register
    always_comb begin
        out_load  = 1'b0;
        out_id    = pend_id_reg;
        out_st    = ST_OK;
        out_last  = 1'b0;
        pend_load = 1'b0;
        pend_clr  = 1'b0;
        if (cw.kind == K_EMIT && step_done && cand_ok) begin
            pend_load = 1'b1;
            out_load  = pend_valid_reg;
        end else if (cw.kind == K_END && step_done) begin
            out_load = 1'b1;
            out_last = 1'b1;
            pend_clr = 1'b1;
            if (cw.err) begin
                out_id = '0;
                out_st = ST_RANGE;
            end else if (!pend_valid_reg) begin
                out_id = '0;
                out_st = ST_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (pend_load) begin
                pend_valid_reg <= 1'b1;
            end else if (pend_clr) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_load) begin
            pend_id_reg <= cand_id;
        end
        if (out_load) begin
            m_id_reg     <= out_id;
            m_status_reg <= out_st;
            m_last_reg   <= out_last;
        end
    end

    assign s_ready           = (cw.kind == K_WAIT);
    assign m_valid           = m_valid_reg;
    assign m_neighbor_region = m_id_reg;
    assign m_status          = m_status_reg;
    assign m_last            = m_last_reg;

endmodule

FILE: hdl/gne_checker.sv
// port-level assertions for the grid neighbor enumerator and their bind
module gne_checker (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [gne_pkg::ID_W-1:0] m_neighbor_region,
    input logic [gne_pkg::ST_W-1:0] m_status,
    input logic                     m_last
);
    import gne_pkg::*;

    // an error or empty status ends the query
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_last)
        else $error("status result without last");

    // an error or empty status carries id zero
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_neighbor_region == '0)
        else $error("status result with nonzero id");

    // one query at a time: no new transfer right after one is taken
    a_one_query: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a query is in work");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_neighbor_region)
            && $stable(m_status) && $stable(m_last))
        else $error("stalled result changed");

endmodule

bind grid_neighbor_enumerator gne_checker u_gne_checker (.*);
